/* rtl/mqtt_publish_framer_defines.svh */
// Assertion macros used by the framer top level.
`ifndef MQTT_PUBLISH_FRAMER_DEFINES_SVH
`define MQTT_PUBLISH_FRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that the consequent holds in the cycle the antecedent holds.
`define MPF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqtt_publish_framer: implication check failed");
// Check that a condition never occurs.
`define MPF_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mqtt_publish_framer: forbidden condition seen");
`else
`define MPF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MPF_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* rtl/mpf_pkg.sv */
// Types and constants shared by the PUBLISH framer modules.
package mpf_pkg;

    // Remaining length is at most 2 + 65535 + 65535 + 2, which needs 18 bits
    localparam int REM_W = 18;

    // Job queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [7:0]  HDR_PUBLISH    = 8'h30;
    localparam logic [7:0]  VARINT_CONT    = 8'h80;
    localparam logic [7:0]  PKT_ID_HI      = 8'h00;
    localparam logic [7:0]  PKT_ID_LO      = 8'h01;
    localparam logic [15:0] MAX_PKT_RESET  = 16'hFFFF;
    localparam logic [1:0]  QOS_INVALID    = 2'd3;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_TOPIC   = 2'd1,
        CMD_PAYLOAD = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TOPIC   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DROP    = 2'd3
    } t_phase;

    // Byte slot within one job
    typedef enum logic [3:0] {
        SL_REJ  = 4'd0,
        SL_HDR  = 4'd1,
        SL_V0   = 4'd2,
        SL_V1   = 4'd3,
        SL_V2   = 4'd4,
        SL_TH   = 4'd5,
        SL_TL   = 4'd6,
        SL_DATA = 4'd7,
        SL_ID0  = 4'd8,
        SL_ID1  = 4'd9
    } t_slot;

    // One classified item waiting for the back end
    typedef struct packed {
        logic             reject;
        logic             hdr_en;
        logic             id_en;
        logic             eop;
        logic [7:0]       fixed_hdr;
        logic [REM_W-1:0] remaining;
        logic [1:0]       vbytes;
        logic [15:0]      topic_bytes;
        logic [7:0]       data;
    } t_job;

endpackage

/* rtl/mpf_front.sv */
// Front end: accepts items, tracks packet state and classifies each item into a job.
module mpf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_command,
    input  logic [15:0]    i_topic_length,
    input  logic [15:0]    i_payload_length,
    input  logic [1:0]     i_qos,
    input  logic           i_retain,
    input  logic [7:0]     i_data_byte,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_max_packet_bytes,
    input  logic           i_queue_full,
    output logic           o_push,
    output mpf_pkg::t_job  o_job
);

    mpf_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_topic_left, n_topic_left;
    logic [15:0] r_payload_left, n_payload_left;
    logic        r_id_pending, n_id_pending;
    logic [15:0] r_max;

    logic                      w_accept;
    logic [mpf_pkg::REM_W-1:0] w_remaining;
    logic [mpf_pkg::REM_W-1:0] w_total;
    logic [1:0]                w_vbytes;
    logic                      w_reject;
    mpf_pkg::t_job             w_job;
    logic                      w_push;

    assign w_accept    = i_in_valid && !i_queue_full;
    assign o_in_ready  = !i_queue_full;
    assign o_cfg_ready = 1'b1;

    // Size the packet: remaining length, varint byte count, whole size
    always_comb begin
        w_remaining = {2'b00, i_topic_length} + {2'b00, i_payload_length}
                    + ((i_qos != 2'd0) ? 18'd4 : 18'd2);
        if (w_remaining[mpf_pkg::REM_W-1:7] == '0) begin
            w_vbytes = 2'd1;
        end else if (w_remaining[mpf_pkg::REM_W-1:14] == '0) begin
            w_vbytes = 2'd2;
        end else begin
            w_vbytes = 2'd3;
        end
        w_total  = w_remaining + 18'd1 + {16'd0, w_vbytes};
        w_reject = (i_qos == mpf_pkg::QOS_INVALID) || (w_total > {2'b00, r_max});
    end

    // Classify the item and advance the packet state
    always_comb begin
        n_phase        = r_phase;
        n_topic_left   = r_topic_left;
        n_payload_left = r_payload_left;
        n_id_pending   = r_id_pending;
        w_push         = 1'b0;
        w_job          = '0;
        w_job.fixed_hdr   = mpf_pkg::HDR_PUBLISH | {5'd0, i_qos, i_retain};
        w_job.remaining   = w_remaining;
        w_job.vbytes      = w_vbytes;
        w_job.topic_bytes = i_topic_length;
        w_job.data        = i_data_byte;
        if (w_accept) begin
            case (i_command)
                mpf_pkg::CMD_START: begin
                    w_push = 1'b1;
                    if (w_reject) begin
                        w_job.reject   = 1'b1;
                        n_phase        = mpf_pkg::PH_DROP;
                        n_topic_left   = '0;
                        n_payload_left = '0;
                        n_id_pending   = 1'b0;
                    end else begin
                        w_job.hdr_en   = 1'b1;
                        n_topic_left   = i_topic_length;
                        n_payload_left = i_payload_length;
                        if (i_topic_length != 16'd0) begin
                            n_id_pending = (i_qos != 2'd0);
                            n_phase      = mpf_pkg::PH_TOPIC;
                        end else begin
                            n_id_pending = 1'b0;
                            w_job.id_en  = (i_qos != 2'd0);
                            w_job.eop    = (i_payload_length == 16'd0);
                            n_phase      = (i_payload_length == 16'd0) ?
                                           mpf_pkg::PH_IDLE : mpf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                mpf_pkg::CMD_TOPIC: begin
                    if (r_phase == mpf_pkg::PH_TOPIC) begin
                        w_push       = 1'b1;
                        n_topic_left = r_topic_left - 16'd1;
                        if (r_topic_left == 16'd1) begin
                            w_job.id_en  = r_id_pending;
                            n_id_pending = 1'b0;
                            w_job.eop    = (r_payload_left == 16'd0);
                            n_phase      = (r_payload_left == 16'd0) ?
                                           mpf_pkg::PH_IDLE : mpf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                mpf_pkg::CMD_PAYLOAD: begin
                    if (r_phase == mpf_pkg::PH_PAYLOAD) begin
                        w_push         = 1'b1;
                        n_payload_left = r_payload_left - 16'd1;
                        if (r_payload_left == 16'd1) begin
                            w_job.eop = 1'b1;
                            n_phase   = mpf_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= mpf_pkg::PH_IDLE;
            r_topic_left   <= '0;
            r_payload_left <= '0;
            r_id_pending   <= 1'b0;
            r_max          <= mpf_pkg::MAX_PKT_RESET;
        end else begin
            r_phase        <= n_phase;
            r_topic_left   <= n_topic_left;
            r_payload_left <= n_payload_left;
            r_id_pending   <= n_id_pending;
            if (i_cfg_valid) begin
                r_max <= i_cfg_max_packet_bytes;
            end
        end
    end

    assign o_push = w_push;
    assign o_job  = w_job;

endmodule

/* rtl/mpf_queue.sv */
// Job queue between the front end and the byte sequencer.
module mpf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mpf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mpf_pkg::t_job o_head
);

    mpf_pkg::t_job r_mem [mpf_pkg::QUEUE_DEPTH];
    logic [mpf_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [mpf_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [mpf_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (mpf_pkg::QUEUE_AW+1)'(mpf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store the incoming job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + {{(mpf_pkg::QUEUE_AW-1){1'b0}}, 1'b1};
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + {{(mpf_pkg::QUEUE_AW-1){1'b0}}, 1'b1};
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + {{mpf_pkg::QUEUE_AW{1'b0}}, 1'b1};
            end else if (!i_push && i_pop) begin
                r_count <= r_count - {{mpf_pkg::QUEUE_AW{1'b0}}, 1'b1};
            end
        end
    end

endmodule

/* rtl/mpf_back.sv */
// Back end: walks each job slot by slot and drives one byte per transaction.
module mpf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  mpf_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_end_of_run,
    output logic          o_end_of_packet,
    output logic          o_rejected
);

    mpf_pkg::t_slot r_slot, n_slot;
    logic           r_first, n_first;
    logic           r_valid;
    logic [7:0]     r_byte;
    logic           r_eor;
    logic           r_eop;
    logic           r_rej;

    mpf_pkg::t_slot w_cur;
    mpf_pkg::t_slot w_nxt;
    logic           w_has_next;
    logic           w_load;
    logic           w_emit;
    logic [7:0]     w_byte;

    assign w_load = !r_valid || i_out_ready;
    assign w_emit = w_load && !i_empty;

    // Pick the current slot and the one after it
    always_comb begin
        if (r_first) begin
            if (i_job.reject) begin
                w_cur = mpf_pkg::SL_REJ;
            end else if (i_job.hdr_en) begin
                w_cur = mpf_pkg::SL_HDR;
            end else begin
                w_cur = mpf_pkg::SL_DATA;
            end
        end else begin
            w_cur = r_slot;
        end
        w_nxt      = mpf_pkg::SL_REJ;
        w_has_next = 1'b0;
        case (w_cur)
            mpf_pkg::SL_HDR: begin
                w_nxt      = mpf_pkg::SL_V0;
                w_has_next = 1'b1;
            end
            mpf_pkg::SL_V0: begin
                w_nxt      = (i_job.vbytes > 2'd1) ? mpf_pkg::SL_V1 : mpf_pkg::SL_TH;
                w_has_next = 1'b1;
            end
            mpf_pkg::SL_V1: begin
                w_nxt      = (i_job.vbytes > 2'd2) ? mpf_pkg::SL_V2 : mpf_pkg::SL_TH;
                w_has_next = 1'b1;
            end
            mpf_pkg::SL_V2: begin
                w_nxt      = mpf_pkg::SL_TH;
                w_has_next = 1'b1;
            end
            mpf_pkg::SL_TH: begin
                w_nxt      = mpf_pkg::SL_TL;
                w_has_next = 1'b1;
            end
            mpf_pkg::SL_TL, mpf_pkg::SL_DATA: begin
                w_nxt      = mpf_pkg::SL_ID0;
                w_has_next = i_job.id_en;
            end
            mpf_pkg::SL_ID0: begin
                w_nxt      = mpf_pkg::SL_ID1;
                w_has_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Next state of the sequencer
    always_comb begin
        n_slot  = r_slot;
        n_first = r_first;
        if (w_emit) begin
            n_first = !w_has_next;
            if (w_has_next) begin
                n_slot = w_nxt;
            end
        end
    end

    // Byte for the current slot
    always_comb begin
        case (w_cur)
            mpf_pkg::SL_HDR:  w_byte = i_job.fixed_hdr;
            mpf_pkg::SL_V0:   w_byte = {1'b0, i_job.remaining[6:0]}
                                     | ((i_job.vbytes > 2'd1) ? mpf_pkg::VARINT_CONT : 8'd0);
            mpf_pkg::SL_V1:   w_byte = {1'b0, i_job.remaining[13:7]}
                                     | ((i_job.vbytes > 2'd2) ? mpf_pkg::VARINT_CONT : 8'd0);
            mpf_pkg::SL_V2:   w_byte = 8'(i_job.remaining[mpf_pkg::REM_W-1:14]);
            mpf_pkg::SL_TH:   w_byte = i_job.topic_bytes[15:8];
            mpf_pkg::SL_TL:   w_byte = i_job.topic_bytes[7:0];
            mpf_pkg::SL_DATA: w_byte = i_job.data;
            mpf_pkg::SL_ID0:  w_byte = mpf_pkg::PKT_ID_HI;
            mpf_pkg::SL_ID1:  w_byte = mpf_pkg::PKT_ID_LO;
            default:          w_byte = 8'd0;
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= mpf_pkg::SL_REJ;
            r_first <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_first <= n_first;
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_byte <= w_byte;
            r_eor  <= !w_has_next;
            r_eop  <= !w_has_next && i_job.eop;
            r_rej  <= (w_cur == mpf_pkg::SL_REJ);
        end
    end

    assign o_pop           = w_emit && !w_has_next;
    assign o_out_valid     = r_valid;
    assign o_out_byte      = r_byte;
    assign o_end_of_run    = r_eor;
    assign o_end_of_packet = r_eop;
    assign o_rejected      = r_rej;

endmodule

/* rtl/mqtt_publish_framer.sv */
// Top level of the MQTT PUBLISH framer: front end, job queue and byte sequencer.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    command, lengths, qos, retain, data byte
//   out      output     o_out_valid / i_out_ready  byte, end of run, end of packet, rejected
//   cfg      input      i_cfg_valid / o_cfg_ready  max_packet_bytes (16 bit)
//
// The output sequencer drives one byte per cycle unless stalled: a rejected start is 1
// byte, an accepted start 4 to 8 (header, 1 to 3 length bytes, topic length, packet id),
// a data item 1 or 3. Items are taken each cycle while the two-entry job queue has room.
// Reset is synchronous and active low; the configuration port is always ready. A stalled
// output holds its register and the queue; the front keeps accepting until full.
`include "mqtt_publish_framer_defines.svh"

module mqtt_publish_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_topic_length,
    input  logic [15:0] i_payload_length,
    input  logic [1:0]  i_qos,
    input  logic        i_retain,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_packet_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_run,
    output logic        o_end_of_packet,
    output logic        o_rejected
);

    logic          w_push;
    logic          w_pop;
    logic          w_queue_full;
    logic          w_queue_empty;
    mpf_pkg::t_job w_job_in;
    mpf_pkg::t_job w_job_head;

    mpf_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_command              (i_command),
        .i_topic_length         (i_topic_length),
        .i_payload_length       (i_payload_length),
        .i_qos                  (i_qos),
        .i_retain               (i_retain),
        .i_data_byte            (i_data_byte),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_max_packet_bytes (i_cfg_max_packet_bytes),
        .i_queue_full           (w_queue_full),
        .o_push                 (w_push),
        .o_job                  (w_job_in)
    );

    mpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_queue_full),
        .o_empty (w_queue_empty),
        .o_head  (w_job_head)
    );

    mpf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_queue_empty),
        .i_job           (w_job_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_end_of_run    (o_end_of_run),
        .o_end_of_packet (o_end_of_packet),
        .o_rejected      (o_rejected)
    );

    // A rejection is a lone, zero byte that closes its run and no packet
    `MPF_ASSERT_IMP(a_reject_form, i_clk, i_rst_n, o_out_valid && o_rejected, o_end_of_run && !o_end_of_packet && (o_out_byte == 8'd0))
    // The last byte of a packet also closes the run of its item
    `MPF_ASSERT_IMP(a_eop_ends_run, i_clk, i_rst_n, o_out_valid && o_end_of_packet, o_end_of_run)
    // Never write a job into a full queue, never pop an empty one
    `MPF_ASSERT_NEVER(a_queue_overrun, i_clk, i_rst_n, (w_push && w_queue_full) || (w_pop && w_queue_empty))

endmodule

/* bench/tb_mqtt_publish_framer.sv */
// Self-checking testbench for the MQTT PUBLISH framer: directed cases and random packet traffic.
`timescale 1ns / 1ps

module tb_mqtt_publish_framer;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         HALF_PERIOD   = 6;
    localparam int         RESET_CYCLES  = 7;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         QUIET_LIMIT   = 4000;
    localparam int         MAX_GAP       = 8;

    // One input transaction as presented on the item channel
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] topic_bytes;
        logic [15:0] payload_bytes;
        logic [1:0]  qos;
        logic        retain;
        logic [7:0]  data;
    } t_pub_item;

    // One expected output transaction
    typedef struct packed {
        logic [7:0] data;
        logic       last_of_item;
        logic       last_of_packet;
        logic       rejected;
    } t_wire_byte;

    logic        i_clk                  = 1'b0;
    logic        i_rst_n                = 1'b0;
    logic        i_in_valid             = 1'b0;
    logic [1:0]  i_command              = 2'd0;
    logic [15:0] i_topic_length         = 16'd0;
    logic [15:0] i_payload_length       = 16'd0;
    logic [1:0]  i_qos                  = 2'd0;
    logic        i_retain               = 1'b0;
    logic [7:0]  i_data_byte            = 8'd0;
    logic        i_cfg_valid            = 1'b0;
    logic [15:0] i_cfg_max_packet_bytes = mpf_pkg::MAX_PKT_RESET;
    logic        i_out_ready            = 1'b0;
    logic        o_in_ready;
    logic        o_cfg_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_end_of_run;
    logic        o_end_of_packet;
    logic        o_rejected;

    // Framer state mirrored by the predictor
    mpf_pkg::t_phase fr_phase        = mpf_pkg::PH_IDLE;
    logic [15:0]     fr_topic_left   = 16'd0;
    logic [15:0]     fr_payload_left = 16'd0;
    logic            fr_id_pending   = 1'b0;
    logic [15:0]     fr_max_packet   = mpf_pkg::MAX_PKT_RESET;

    t_wire_byte  item_beats [0:7];
    int          n_beats;
    t_wire_byte  wire_bytes_due [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int items_framed    = 0;
    int items_swallowed = 0;
    int bytes_checked   = 0;
    int limits_used     = 0;
    int quiet_cycles    = 0;

    mqtt_publish_framer dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_command              (i_command),
        .i_topic_length         (i_topic_length),
        .i_payload_length       (i_payload_length),
        .i_qos                  (i_qos),
        .i_retain               (i_retain),
        .i_data_byte            (i_data_byte),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_max_packet_bytes (i_cfg_max_packet_bytes),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_out_byte             (o_out_byte),
        .o_end_of_run           (o_end_of_run),
        .o_end_of_packet        (o_end_of_packet),
        .o_rejected             (o_rejected)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Packet predictor
    // ------------------------------------------------------------------

    function automatic void add_beat(input logic [7:0] value, input logic rej);
        item_beats[n_beats] = '{data: value, last_of_item: 1'b0, last_of_packet: 1'b0,
                                rejected: rej};
        n_beats++;
    endfunction

    // Topic done: append the packet id if owed, then move to payload or close the packet
    function automatic void close_topic();
        if (fr_id_pending) begin
            add_beat(mpf_pkg::PKT_ID_HI, 1'b0);
            add_beat(mpf_pkg::PKT_ID_LO, 1'b0);
            fr_id_pending = 1'b0;
        end
        if (fr_payload_left == 16'd0) begin
            item_beats[n_beats-1].last_of_packet = 1'b1;
            fr_phase = mpf_pkg::PH_IDLE;
        end else begin
            fr_phase = mpf_pkg::PH_PAYLOAD;
        end
    endfunction

    // Work out the wire bytes one accepted transaction causes and queue them
    function automatic int frame_item(input t_pub_item it);
        logic [31:0] remaining;
        logic [31:0] total;
        logic [31:0] rest;
        logic [7:0]  chunk;
        int          vbytes;
        int          k;
        n_beats = 0;
        if (it.command == mpf_pkg::CMD_START) begin
            remaining = 32'd2 + it.topic_bytes + it.payload_bytes
                      + ((it.qos != 2'd0) ? 32'd2 : 32'd0);
            vbytes = 0;
            rest   = remaining;
            do begin
                vbytes++;
                rest = rest / 128;
            end while (rest > 0);
            total = 32'd1 + vbytes + remaining;
            if (it.qos == mpf_pkg::QOS_INVALID || total > fr_max_packet) begin
                add_beat(8'h00, 1'b1);
                fr_phase        = mpf_pkg::PH_DROP;
                fr_topic_left   = 16'd0;
                fr_payload_left = 16'd0;
                fr_id_pending   = 1'b0;
            end else begin
                add_beat(mpf_pkg::HDR_PUBLISH | {5'd0, it.qos, it.retain}, 1'b0);
                // Remaining length, seven bits at a time, low group first
                rest = remaining;
                do begin
                    chunk = {1'b0, rest[6:0]};
                    rest  = rest / 128;
                    if (rest > 0)
                        chunk = chunk | mpf_pkg::VARINT_CONT;
                    add_beat(chunk, 1'b0);
                end while (rest > 0);
                add_beat(it.topic_bytes[15:8], 1'b0);
                add_beat(it.topic_bytes[7:0], 1'b0);
                fr_topic_left   = it.topic_bytes;
                fr_payload_left = it.payload_bytes;
                fr_id_pending   = (it.qos != 2'd0);
                if (fr_topic_left != 16'd0)
                    fr_phase = mpf_pkg::PH_TOPIC;
                else
                    close_topic();
            end
        end else if (it.command == mpf_pkg::CMD_TOPIC && fr_phase == mpf_pkg::PH_TOPIC) begin
            add_beat(it.data, 1'b0);
            fr_topic_left = fr_topic_left - 16'd1;
            if (fr_topic_left == 16'd0)
                close_topic();
        end else if (it.command == mpf_pkg::CMD_PAYLOAD
                     && fr_phase == mpf_pkg::PH_PAYLOAD) begin
            add_beat(it.data, 1'b0);
            fr_payload_left = fr_payload_left - 16'd1;
            if (fr_payload_left == 16'd0) begin
                item_beats[n_beats-1].last_of_packet = 1'b1;
                fr_phase = mpf_pkg::PH_IDLE;
            end
        end
        if (n_beats > 0)
            item_beats[n_beats-1].last_of_item = 1'b1;
        for (k = 0; k < n_beats; k++)
            wire_bytes_due.push_back(item_beats[k]);
        return n_beats;
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    function automatic t_pub_item start_item(input logic [15:0] tl, input logic [15:0] pl,
                                             input logic [1:0] q, input logic ret);
        t_pub_item it;
        it.command       = mpf_pkg::CMD_START;
        it.topic_bytes   = tl;
        it.payload_bytes = pl;
        it.qos           = q;
        it.retain        = ret;
        it.data          = 8'($urandom_range(255));
        return it;
    endfunction

    // Data transaction; the fields used on a start only carry junk
    function automatic t_pub_item data_item(input logic [1:0] cmd, input logic [7:0] value);
        t_pub_item it;
        it.command       = cmd;
        it.topic_bytes   = 16'($urandom_range(65535));
        it.payload_bytes = 16'($urandom_range(65535));
        it.qos           = 2'($urandom_range(3));
        it.retain        = 1'($urandom_range(1));
        it.data          = value;
        return it;
    endfunction

    function automatic t_pub_item random_item();
        t_pub_item it;
        it         = data_item(CMD_UNUSED, 8'($urandom_range(255)));
        it.command = 2'($urandom_range(3));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Present one item from a falling edge, hold it until taken, predict on acceptance
    task automatic send_item(input t_pub_item it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            gap++;
        end
        i_in_valid       <= 1'b1;
        i_command        <= it.command;
        i_topic_length   <= it.topic_bytes;
        i_payload_length <= it.payload_bytes;
        i_qos            <= it.qos;
        i_retain         <= it.retain;
        i_data_byte      <= it.data;
        do @(posedge i_clk); while (!o_in_ready);
        if (frame_item(it) > 0)
            items_framed++;
        else
            items_swallowed++;
        @(negedge i_clk);
    endtask

    // Hold the sender off until every expected byte is out and the pipe has emptied
    task automatic settle();
        i_in_valid <= 1'b0;
        while (wire_bytes_due.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        i_cfg_valid            <= 1'b1;
        i_cfg_max_packet_bytes <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        fr_max_packet = value;
        limits_used++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Receiver: drop ready at random for the current stall rate
    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // Output checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each output transaction with the oldest expected byte
    always @(posedge i_clk) begin : check_wire
        t_wire_byte want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bytes_checked++;
            if (wire_bytes_due.size() == 0) begin
                $error("unexpected output transaction: out_byte %0h rejected %0b",
                       o_out_byte, o_rejected);
                error_count++;
            end else begin
                want = wire_bytes_due.pop_front();
                // The byte carries nothing on a rejection
                if (!want.rejected)
                    check_field("out_byte", want.data, o_out_byte);
                check_field("end_of_run", {7'd0, want.last_of_item}, {7'd0, o_end_of_run});
                check_field("end_of_packet", {7'd0, want.last_of_packet},
                            {7'd0, o_end_of_packet});
                check_field("rejected", {7'd0, want.rejected}, {7'd0, o_rejected});
            end
        end
    end

    // Abort when no channel has moved a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_mqtt_publish_framer NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Header forms for each QoS, retain, empty body and the invalid QoS
    task automatic test_header_forms();
        send_item(start_item(16'd0, 16'd0, 2'd0, 1'b0));
        send_item(start_item(16'd1, 16'd1, 2'd1, 1'b1));
        send_item(data_item(mpf_pkg::CMD_TOPIC, 8'hFF));
        send_item(data_item(mpf_pkg::CMD_PAYLOAD, 8'h00));
        send_item(start_item(16'd0, 16'd0, 2'd2, 1'b0));
        send_item(start_item(16'd0, 16'd0, mpf_pkg::QOS_INVALID, 1'b1));
        send_item(data_item(mpf_pkg::CMD_TOPIC, 8'h55));
        send_item(data_item(mpf_pkg::CMD_PAYLOAD, 8'hAA));
    endtask

    // Bytes in the wrong phase and the unused command leave the packet intact
    task automatic test_stray_bytes();
        send_item(data_item(mpf_pkg::CMD_PAYLOAD, 8'h3C));
        send_item(start_item(16'd2, 16'd1, 2'd0, 1'b0));
        send_item(data_item(mpf_pkg::CMD_PAYLOAD, 8'h34));
        send_item(data_item(CMD_UNUSED, 8'hE7));
        send_item(data_item(mpf_pkg::CMD_TOPIC, 8'h12));
        send_item(data_item(mpf_pkg::CMD_TOPIC, 8'h56));
        send_item(data_item(mpf_pkg::CMD_TOPIC, 8'h9A));
        send_item(data_item(mpf_pkg::CMD_PAYLOAD, 8'h78));
        send_item(data_item(mpf_pkg::CMD_PAYLOAD, 8'hC3));
    endtask

    // Remaining length across the one, two and three byte boundaries; each start after the
    // first abandons the packet before it
    task automatic test_length_encoding();
        send_item(start_item(16'd125, 16'd0, 2'd0, 1'b0));
        send_item(start_item(16'd126, 16'd0, 2'd0, 1'b1));
        send_item(start_item(16'd16382, 16'd0, 2'd0, 1'b0));
        send_item(start_item(16'd0, 16'd20000, 2'd2, 1'b1));
        send_item(data_item(mpf_pkg::CMD_PAYLOAD, 8'hFF));
        send_item(start_item(16'hFFFF, 16'hFFFF, 2'd2, 1'b1));
    endtask

    // Packet size right at the limit and one above, then a limit of one byte
    task automatic test_size_limit();
        settle();
        write_limit(16'd10);
        send_item(start_item(16'd2, 16'd2, 2'd1, 1'b0));
        send_item(data_item(mpf_pkg::CMD_TOPIC, 8'h81));
        send_item(start_item(16'd2, 16'd3, 2'd1, 1'b1));
        settle();
        write_limit(16'd1);
        send_item(start_item(16'd0, 16'd0, 2'd0, 1'b0));
        settle();
        write_limit(mpf_pkg::MAX_PKT_RESET);
    endtask

    // Mostly well-formed packets with random content, some cut short, plus noise
    task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct,
                                       input logic [15:0] limit);
        int          target;
        int          body;
        int          k;
        bit          cut;
        bit          paused;
        logic [15:0] tl;
        logic [15:0] pl;
        logic [1:0]  q;
        settle();
        write_limit(limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target = items_framed + items_swallowed + n_items;
        paused = 1'b0;
        while (items_framed + items_swallowed < target) begin
            if ($urandom_range(99) < 4) begin
                send_item(random_item());
            end else begin
                q = ($urandom_range(99) < 6) ? mpf_pkg::QOS_INVALID : 2'($urandom_range(2));
                if ($urandom_range(99) < 6) begin
                    tl  = 16'($urandom_range(16400, 100));
                    pl  = 16'($urandom_range(300));
                    cut = 1'b1;
                end else begin
                    tl  = 16'($urandom_range(6));
                    pl  = 16'($urandom_range(8));
                    cut = ($urandom_range(99) < 8);
                end
                body = int'(tl) + int'(pl);
                if (cut)
                    body = $urandom_range((body < 6) ? body : 6);
                send_item(start_item(tl, pl, q, 1'($urandom_range(1))));
                for (k = 0; k < body; k++) begin
                    if ($urandom_range(99) < 3)
                        send_item(random_item());
                    send_item(data_item((k < int'(tl)) ? mpf_pkg::CMD_TOPIC
                                                       : mpf_pkg::CMD_PAYLOAD,
                                        8'($urandom_range(255))));
                end
            end
            // Hold the sender once per phase until the framer has drained
            if (!paused && items_framed + items_swallowed >= target - n_items / 2) begin
                settle();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_header_forms();
        test_stray_bytes();
        test_length_encoding();
        test_size_limit();
        test_random_traffic(65, 0, 0, mpf_pkg::MAX_PKT_RESET);
        test_random_traffic(65, 48, 0, 16'($urandom_range(60, 20)));
        test_random_traffic(65, 0, 48, mpf_pkg::MAX_PKT_RESET);
        test_random_traffic(70, 28, 28, 16'($urandom_range(30, 8)));
        test_random_traffic(15, 28, 28, 16'd1);
        settle();

        $display("Framed %0d input transactions (%0d more dropped) into %0d output bytes",
                 items_framed, items_swallowed, bytes_checked);
        $display("across %0d size limits, with sender gaps and receiver stalls mixed",
                 limits_used);
        if (error_count == 0)
            $display("tb_mqtt_publish_framer OK");
        else
            $display("tb_mqtt_publish_framer NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/mpf_pkg.sv
rtl/mpf_front.sv
rtl/mpf_queue.sv
rtl/mpf_back.sv
rtl/mqtt_publish_framer.sv
bench/tb_mqtt_publish_framer.sv
